[rtl/core/ssfp_pkg.sv]
// ssfp_pkg: types and constants shared by the servo status frame parser
// holds the queue word and result word layouts, frame constants and defaults
// no dependencies
package ssfp_pkg;

   localparam int MAX_FRAME_DEFAULT   = 64;
   localparam int SERVO_SLOTS_DEFAULT = 16;

   localparam int KEPT_BYTES = 13;
   localparam int MIN_FRAME  = 14;
   localparam int SLOT_W     = 4;
   localparam int OFFSET_SLOTS = 2 ** SLOT_W;

   localparam logic [7:0]  HEAD_BYTE = 8'hFF;
   localparam logic [7:0]  NO_ERROR  = 8'h00;
   localparam logic [15:0] CENTER    = 16'd2048;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 2;

   typedef enum logic {
      ENTRY_LOAD  = 1'b0,
      ENTRY_FRAME = 1'b1
   } entry_kind_type;

   typedef struct packed {
      entry_kind_type    kind;
      logic [SLOT_W-1:0] slot;
      logic [15:0]       offset;
      logic [7:0]        id;
      logic [15:0]       raw_position;
      logic [15:0]       speed;
      logic [15:0]       load;
      logic [7:0]        voltage;
      logic [7:0]        temperature;
   } mid_entry_type;

   typedef struct packed {
      logic [3:0]  unit_id;
      logic [15:0] position;
      logic [15:0] speed;
      logic [15:0] load;
      logic [7:0]  voltage;
      logic [7:0]  temperature;
   } rsp_word_type;

endpackage

[rtl/core/ssfp_fifo.sv]
// ssfp_fifo: small register queue with full and empty flags
// used between front and back and on the result side; depends on nothing
module ssfp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(full && empty))
      else $error("queue full and empty together");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> !empty)
      else $error("queue empty after a word was written");

endmodule

[rtl/core/ssfp_front.sv]
// ssfp_front: byte-level frame tracking, checksum and header checks
// hands finished frames and offset loads to the middle queue; uses ssfp_pkg
module ssfp_front #(
   parameter int MAX_FRAME   = ssfp_pkg::MAX_FRAME_DEFAULT,
   parameter int SERVO_SLOTS = ssfp_pkg::SERVO_SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   req_command,
   input  logic [7:0]             req_rx_byte,
   input  logic                   req_end_of_frame,
   input  logic [3:0]             req_servo_slot,
   input  logic [15:0]            req_zero_offset,
   output logic                   mid_push,
   output ssfp_pkg::mid_entry_type mid_entry
);

   import ssfp_pkg::*;

   localparam int IDX_W = $clog2(MAX_FRAME + 1);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       sum_ff, sum_in;
   logic             overflowed_ff, overflowed_in;
   logic [7:0]       bytes_ff [KEPT_BYTES];
   logic             over;
   logic             frame_ok;
   logic             load_ok;
   logic             is_byte;

   assign is_byte = accept && (req_command == CMD_BYTE);
   assign over    = overflowed_ff || (idx_ff >= IDX_W'(MAX_FRAME));

   // an accepted frame is at least KEPT_BYTES + 1 long, so the kept bytes
   // are all from this frame and the last byte is never among them
   assign frame_ok = !over
                  && (idx_ff >= IDX_W'(MIN_FRAME - 1))
                  && (bytes_ff[0] == HEAD_BYTE)
                  && (bytes_ff[1] == HEAD_BYTE)
                  && (bytes_ff[4] == NO_ERROR)
                  && (req_rx_byte == ~sum_ff)
                  && ({1'b0, bytes_ff[2]} < 9'(SERVO_SLOTS));

   assign load_ok = ({5'b0, req_servo_slot} < 9'(SERVO_SLOTS));

   always_comb begin
      idx_in        = idx_ff;
      sum_in        = sum_ff;
      overflowed_in = overflowed_ff;
      if (is_byte) begin
         if (req_end_of_frame) begin
            idx_in        = '0;
            sum_in        = '0;
            overflowed_in = 1'b0;
         end else if (over) begin
            overflowed_in = 1'b1;
         end else begin
            if (idx_ff >= IDX_W'(2)) begin
               sum_in = sum_ff + req_rx_byte;
            end
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         sum_ff        <= '0;
         overflowed_ff <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         sum_ff        <= sum_in;
         overflowed_ff <= overflowed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_byte && (idx_ff < IDX_W'(KEPT_BYTES))) begin
         bytes_ff[idx_ff[3:0]] <= req_rx_byte;
      end
   end

   always_comb begin
      mid_push = 1'b0;
      if (accept) begin
         mid_push = (req_command == CMD_LOAD) ? load_ok : (req_end_of_frame && frame_ok);
      end
      mid_entry.kind         = (req_command == CMD_LOAD) ? ENTRY_LOAD : ENTRY_FRAME;
      mid_entry.slot         = req_servo_slot;
      mid_entry.offset       = req_zero_offset;
      mid_entry.id           = bytes_ff[2];
      mid_entry.raw_position = {bytes_ff[6], bytes_ff[5]};
      mid_entry.speed        = {bytes_ff[8], bytes_ff[7]};
      mid_entry.load         = {bytes_ff[10], bytes_ff[9]};
      mid_entry.voltage      = bytes_ff[11];
      mid_entry.temperature  = bytes_ff[12];
   end

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(MAX_FRAME))
      else $error("byte index beyond frame limit");

   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      (is_byte && req_end_of_frame) |=> (idx_ff == '0 && sum_ff == '0 && !overflowed_ff))
      else $error("frame state not cleared after end of frame");

   a_overflow_at_limit: assert property (@(posedge clock) disable iff (reset)
      overflowed_ff |-> (idx_ff == IDX_W'(MAX_FRAME)))
      else $error("overflow flag set below frame limit");

endmodule

[rtl/core/ssfp_back.sv]
// ssfp_back: zero offset table and position correction
// drains the middle queue into the result queue; uses ssfp_pkg
module ssfp_back #(
   parameter int SERVO_SLOTS = ssfp_pkg::SERVO_SLOTS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    mid_empty,
   input  ssfp_pkg::mid_entry_type mid_head,
   input  logic                    out_full,
   output logic                    mid_pop,
   output logic                    out_push,
   output ssfp_pkg::rsp_word_type  out_word
);

   import ssfp_pkg::*;

   // only slots reachable by a load need storage, the rest read as zero
   localparam int TBL_DEPTH = (SERVO_SLOTS < OFFSET_SLOTS) ? SERVO_SLOTS : OFFSET_SLOTS;
   localparam int TBL_W     = $clog2(TBL_DEPTH);

   logic [15:0] table_ff [TBL_DEPTH];
   logic [15:0] offset;
   logic        is_load;

   assign is_load  = (mid_head.kind == ENTRY_LOAD);
   assign mid_pop  = !mid_empty && (is_load || !out_full);
   assign out_push = !mid_empty && !is_load && !out_full;

   always_comb begin
      offset = '0;
      if (mid_head.id < 8'(TBL_DEPTH)) begin
         offset = table_ff[mid_head.id[TBL_W-1:0]];
      end
      out_word.unit_id     = mid_head.id[3:0];
      out_word.position    = mid_head.raw_position - offset - CENTER;
      out_word.speed       = mid_head.speed;
      out_word.load        = mid_head.load;
      out_word.voltage     = mid_head.voltage;
      out_word.temperature = mid_head.temperature;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TBL_DEPTH; i++) begin
            table_ff[i] <= '0;
         end
      end else if (mid_pop && is_load) begin
         table_ff[mid_head.slot[TBL_W-1:0]] <= mid_head.offset;
      end
   end

   a_push_needs_head: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (mid_pop && !mid_empty))
      else $error("result written without a queued frame");

   a_load_in_range: assert property (@(posedge clock) disable iff (reset)
      (mid_pop && is_load) |-> ({5'b0, mid_head.slot} < 9'(TBL_DEPTH)))
      else $error("offset load beyond table");

   a_no_stall_load: assert property (@(posedge clock) disable iff (reset)
      (!mid_empty && is_load) |-> mid_pop)
      else $error("offset load held back");

endmodule

[rtl/core/servo_status_frame_parser.sv]
// servo_status_frame_parser: top level of the servo status frame parser
// instantiates ssfp_front, ssfp_back and two ssfp_fifo queues; uses ssfp_pkg
//
// usage:
//   request side is a queue input: drive req_* and raise req_push; the word is
//   taken on a rising edge with req_push high and req_full low. req_command 0
//   carries one frame byte (req_end_of_frame marks the last byte of a frame),
//   req_command 1 loads the zero offset of slot req_servo_slot.
//   result side is a queue output: while rsp_empty is low the oldest result
//   sits on rsp_*, and it is taken on an edge with rsp_pop high.
//   one word is taken every cycle while req_full is low; a good frame is
//   checked in the front and queued on the edge that takes its last byte;
//   offset lookup and subtract in the back part then write its result.
//   bad, short or long frames and offset loads give no result.
//   a four-word queue sits between front and back and a two-word result queue
//   at the output; when the receiver stalls they fill and req_full rises.
//   reset clears frame tracking, both queues and the zero offset table.
module servo_status_frame_parser #(
   parameter int MAX_FRAME   = ssfp_pkg::MAX_FRAME_DEFAULT,
   parameter int SERVO_SLOTS = ssfp_pkg::SERVO_SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_command,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_end_of_frame,
   input  logic [3:0]         req_servo_slot,
   input  logic signed [15:0] req_zero_offset,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [3:0]         rsp_unit_id,
   output logic signed [15:0] rsp_position,
   output logic [15:0]        rsp_speed,
   output logic [15:0]        rsp_load,
   output logic [7:0]         rsp_voltage,
   output logic [7:0]         rsp_temperature
);

   import ssfp_pkg::*;

   localparam int MID_W = $bits(mid_entry_type);
   localparam int OUT_W = $bits(rsp_word_type);

   logic          accept;
   logic          mid_push, mid_pop, mid_full, mid_empty;
   mid_entry_type mid_entry, mid_head;
   logic [MID_W-1:0] mid_rd_data;
   logic          out_push, out_full;
   rsp_word_type  out_word, rsp_word;
   logic [OUT_W-1:0] out_rd_data;

   assign req_full = mid_full;
   assign accept   = req_push && !mid_full;

   ssfp_front #(
      .MAX_FRAME   (MAX_FRAME),
      .SERVO_SLOTS (SERVO_SLOTS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_command      (req_command),
      .req_rx_byte      (req_rx_byte),
      .req_end_of_frame (req_end_of_frame),
      .req_servo_slot   (req_servo_slot),
      .req_zero_offset  (req_zero_offset),
      .mid_push         (mid_push),
      .mid_entry        (mid_entry)
   );

   ssfp_fifo #(
      .WIDTH (MID_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .wr_data (mid_entry),
      .pop     (mid_pop),
      .rd_data (mid_rd_data),
      .full    (mid_full),
      .empty   (mid_empty)
   );

   assign mid_head = mid_entry_type'(mid_rd_data);

   ssfp_back #(
      .SERVO_SLOTS (SERVO_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_head  (mid_head),
      .out_full  (out_full),
      .mid_pop   (mid_pop),
      .out_push  (out_push),
      .out_word  (out_word)
   );

   ssfp_fifo #(
      .WIDTH (OUT_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_word),
      .pop     (rsp_pop),
      .rd_data (out_rd_data),
      .full    (out_full),
      .empty   (rsp_empty)
   );

   assign rsp_word        = rsp_word_type'(out_rd_data);
   assign rsp_unit_id     = rsp_word.unit_id;
   assign rsp_position    = rsp_word.position;
   assign rsp_speed       = rsp_word.speed;
   assign rsp_load        = rsp_word.load;
   assign rsp_voltage     = rsp_word.voltage;
   assign rsp_temperature = rsp_word.temperature;

endmodule
